// ===== rtl/cchp_pkg.sv =====
`default_nettype none
package cchp_pkg;

  // field widths
  localparam int POS_W   = 24;
  localparam int LOOK_W  = 23;
  localparam int GAIN_W  = 16;
  localparam int YAW_W   = 16;
  localparam int RATE_W  = 32;
  localparam int DIST_W  = 25;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 3;

  // internal widths
  localparam int DIFF_W   = POS_W + 1;
  localparam int OPA_W    = 33;
  localparam int OPB_W    = 26;
  localparam int MAGA_W   = 32;
  localparam int MAGB_W   = 25;
  localparam int PROD_W   = MAGA_W + MAGB_W;
  localparam int ACC_W    = 54;
  localparam int LEN_W    = 26;
  localparam int REACH_W  = 26;
  localparam int QUO_W    = 28;
  localparam int CAR_W    = 30;
  localparam int CX_W     = 48;
  localparam int ANG_W    = 28;
  localparam int ERR_W    = 16;
  localparam int SUM_W    = 32;
  localparam int RAD_W    = 50;
  localparam int SREM_W   = 29;
  localparam int CNT_W    = 6;

  localparam int MUL_STEPS  = MAGB_W;
  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_STEPS = RAD_W / 2;

  localparam int CORDIC_ITERS = 16;
  localparam int PI_Q13       = 25736;
  localparam int TWO_PI_Q13   = 51472;
  localparam int PI_Q24       = 52707179;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_START_X    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_START_Y    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_GOAL_X     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GOAL_Y     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_LOOKAHEAD  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_GAIN_PROP  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_GAIN_DERIV = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_GAIN_INTEG = 3'd7;

  typedef struct packed {
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic [LOOK_W-1:0]       lookahead;
    logic [GAIN_W-1:0]       gain_prop;
    logic [GAIN_W-1:0]       gain_deriv;
    logic [GAIN_W-1:0]       gain_integ;
  } cfg_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] angular_rate;
    logic [DIST_W-1:0]        goal_distance;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MLOAD, ST_MUL, ST_MACC, ST_DLOAD, ST_DIV, ST_DIV_END,
    ST_SLOAD, ST_SQRT, ST_SQRT_END, ST_CINIT, ST_CORD_Y, ST_CORD_X,
    ST_WRAP, ST_RATE, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    SP_LEN_X, SP_LEN_Y, SP_DOT_X, SP_DOT_Y, SP_CAR_X, SP_CAR_Y,
    SP_KP, SP_KD, SP_KI, SP_GOAL_X, SP_GOAL_Y
  } step_e;

  // arctan(2^-i) in Q24 radians
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/carrot_chasing_heading_pid.sv =====
`default_nettype none
// Carrot-chasing heading controller. Each input beat is a pose (pos_x, pos_y in Q7.16 m,
// yaw in Q2.13 rad). The block projects the pose onto the start-to-goal line, places a
// carrot lookahead metres further along it, takes the CORDIC angle to the carrot, forms
// the heading error wrapped once into [-pi, pi] and runs a PID on it; each pose gives one
// output beat with angular_rate (Q18.13, saturating) and goal_distance (Q9.16 m, rounded).
// All arithmetic goes through one small sequencer driving bit-serial units: a shift-add
// multiplier (25 steps, used 11 times), a restoring divider (54 steps, used 3 times), a
// bit-pair square root (25 steps, used twice) and a 16-iteration CORDIC that runs each
// iteration as a Y update state followed by an X update state. in_ready_o
// is high only while the sequencer is idle; the result sits in an output register so the
// next pose can be taken while it waits for out_ready_i. The error sum and previous error
// persist between poses and are cleared by reset only. Registers are written through a
// plain write port (index 0..7: start_x, start_y, goal_x, goal_y, lookahead, gain_prop,
// gain_deriv, gain_integ) and should only change while the block is idle.
module carrot_chasing_heading_pid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [15:0] yaw_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      angular_rate_o,
  output logic [24:0]             goal_distance_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);
  import cchp_pkg::*;

  cfg_t cfg_q, cfg_d;
  res_t res_q, res_d, eng_res;
  logic out_valid_q, out_valid_d;
  logic eng_idle, eng_done, out_free, start;

  // register file writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_X:    cfg_d.start_x    = cfg_data_i;
        CFG_START_Y:    cfg_d.start_y    = cfg_data_i;
        CFG_GOAL_X:     cfg_d.goal_x     = cfg_data_i;
        CFG_GOAL_Y:     cfg_d.goal_y     = cfg_data_i;
        CFG_LOOKAHEAD:  cfg_d.lookahead  = cfg_data_i[LOOK_W-1:0];
        CFG_GAIN_PROP:  cfg_d.gain_prop  = cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_DERIV: cfg_d.gain_deriv = cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_INTEG: cfg_d.gain_integ = cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign start      = in_valid_i && eng_idle;
  assign in_ready_o = eng_idle;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (eng_done) begin
      out_valid_d = 1'b1;
      res_d       = eng_res;
    end
  end

  cchp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .yaw_i      (yaw_i),
    .out_free_i (out_free),
    .idle_o     (eng_idle),
    .done_o     (eng_done),
    .res_o      (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x    <= 24'sd262144;
      cfg_q.start_y    <= 24'sd98304;
      cfg_q.goal_x     <= -24'sd196608;
      cfg_q.goal_y     <= 24'sd98304;
      cfg_q.lookahead  <= 23'd13107;
      cfg_q.gain_prop  <= 16'd1024;
      cfg_q.gain_deriv <= 16'd1600;
      cfg_q.gain_integ <= 16'd0;
      out_valid_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign angular_rate_o  = res_q.angular_rate;
  assign goal_distance_o = res_q.goal_distance;

endmodule
`default_nettype wire

// ===== rtl/cchp_engine.sv =====
`default_nettype none
module cchp_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cchp_pkg::cfg_t               cfg_i,
  input  wire logic                         start_i,
  input  wire logic signed [23:0]           pos_x_i,
  input  wire logic signed [23:0]           pos_y_i,
  input  wire logic signed [15:0]           yaw_i,
  input  wire logic                         out_free_i,
  output logic                              idle_o,
  output logic                              done_o,
  output cchp_pkg::res_t                    res_o
);
  import cchp_pkg::*;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic signed [ERR_W-1:0] prev_q, prev_d;
  logic signed [SUM_W-1:0] esum_q, esum_d;

  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d;
  logic signed [YAW_W-1:0] yaw_q, yaw_d;
  logic [MAGA_W-1:0]       mcand_q, mcand_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    mneg_q, mneg_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0]        wk_q, wk_d;
  logic [SREM_W-1:0]       rem_q, rem_d;
  logic [LEN_W-1:0]        root_q, root_d;
  logic                    dneg_q, dneg_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [REACH_W-1:0]      reach_q, reach_d;
  logic signed [CAR_W-1:0] carx_q, carx_d, cary_q, cary_d;
  logic signed [CX_W-1:0]  cx_q, cx_d, cy_q, cy_d, ysav_q, ysav_d;
  logic                    dir_q, dir_d;
  logic signed [ANG_W-1:0] ang_q, ang_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic signed [RATE_W-1:0] rate_q, rate_d;
  logic [DIST_W-1:0]       gdist_q, gdist_d;

  // path geometry
  logic signed [DIFF_W-1:0] dx_raw, dy_raw, dx, dy, ux, uy, gx, gy;
  logic                     degen;

  always_comb begin
    dx_raw = $signed({cfg_i.goal_x[POS_W-1], cfg_i.goal_x})
           - $signed({cfg_i.start_x[POS_W-1], cfg_i.start_x});
    dy_raw = $signed({cfg_i.goal_y[POS_W-1], cfg_i.goal_y})
           - $signed({cfg_i.start_y[POS_W-1], cfg_i.start_y});
    degen  = (dx_raw == '0) && (dy_raw == '0);
    dx     = degen ? DIFF_W'(1) : dx_raw;
    dy     = degen ? '0 : dy_raw;
    ux = $signed({px_q[POS_W-1], px_q}) - $signed({cfg_i.start_x[POS_W-1], cfg_i.start_x});
    uy = $signed({py_q[POS_W-1], py_q}) - $signed({cfg_i.start_y[POS_W-1], cfg_i.start_y});
    gx = $signed({px_q[POS_W-1], px_q}) - $signed({cfg_i.goal_x[POS_W-1], cfg_i.goal_x});
    gy = $signed({py_q[POS_W-1], py_q}) - $signed({cfg_i.goal_y[POS_W-1], cfg_i.goal_y});
  end

  // multiplier operand select
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic [OPA_W-1:0]        neg_a;
  logic [OPB_W-1:0]        neg_b;
  logic [MAGA_W-1:0]       mag_a;
  logic [MAGB_W-1:0]       mag_b;
  logic signed [ERR_W:0]   ediff;

  always_comb begin
    ediff = $signed({err_q[ERR_W-1], err_q}) - $signed({prev_q[ERR_W-1], prev_q});
    case (step_q)
      SP_LEN_X:  begin op_a = {{8{dx[DIFF_W-1]}}, dx}; op_b = {dx[DIFF_W-1], dx}; end
      SP_LEN_Y:  begin op_a = {{8{dy[DIFF_W-1]}}, dy}; op_b = {dy[DIFF_W-1], dy}; end
      SP_DOT_X:  begin op_a = {{8{ux[DIFF_W-1]}}, ux}; op_b = {dx[DIFF_W-1], dx}; end
      SP_DOT_Y:  begin op_a = {{8{uy[DIFF_W-1]}}, uy}; op_b = {dy[DIFF_W-1], dy}; end
      SP_CAR_X:  begin op_a = {7'b0, reach_q}; op_b = {dx[DIFF_W-1], dx}; end
      SP_CAR_Y:  begin op_a = {7'b0, reach_q}; op_b = {dy[DIFF_W-1], dy}; end
      SP_KP:     begin
        op_a = {{17{err_q[ERR_W-1]}}, err_q}; op_b = {10'b0, cfg_i.gain_prop};
      end
      SP_KD:     begin
        op_a = {{16{ediff[ERR_W]}}, ediff}; op_b = {10'b0, cfg_i.gain_deriv};
      end
      SP_KI:     begin
        op_a = {esum_q[SUM_W-1], esum_q}; op_b = {10'b0, cfg_i.gain_integ};
      end
      SP_GOAL_X: begin op_a = {{8{gx[DIFF_W-1]}}, gx}; op_b = {gx[DIFF_W-1], gx}; end
      SP_GOAL_Y: begin op_a = {{8{gy[DIFF_W-1]}}, gy}; op_b = {gy[DIFF_W-1], gy}; end
      default:   begin op_a = '0; op_b = '0; end
    endcase
    neg_a = -op_a;
    neg_b = -op_b;
    mag_a = op_a[OPA_W-1] ? neg_a[MAGA_W-1:0] : op_a[MAGA_W-1:0];
    mag_b = op_b[OPB_W-1] ? neg_b[MAGB_W-1:0] : op_b[MAGB_W-1:0];
  end

  // next state
  logic last_cnt_mul, last_cnt_div, last_cnt_sqrt, last_cnt_cord, car_zero;

  always_comb begin
    last_cnt_mul  = (cnt_q == CNT_W'(MUL_STEPS - 1));
    last_cnt_div  = (cnt_q == CNT_W'(DIV_STEPS - 1));
    last_cnt_sqrt = (cnt_q == CNT_W'(SQRT_STEPS - 1));
    last_cnt_cord = (cnt_q == CNT_W'(CORDIC_ITERS - 1));
    car_zero      = (carx_q == '0) && (cary_q == '0);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MLOAD;
          step_d  = SP_LEN_X;
        end
      end
      ST_MLOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (last_cnt_mul) state_d = ST_MACC;
      end
      ST_MACC: begin
        case (step_q)
          SP_LEN_X:  begin state_d = ST_MLOAD; step_d = SP_LEN_Y; end
          SP_DOT_X:  begin state_d = ST_MLOAD; step_d = SP_DOT_Y; end
          SP_KP:     begin state_d = ST_MLOAD; step_d = SP_KD; end
          SP_KD:     begin state_d = ST_MLOAD; step_d = SP_KI; end
          SP_GOAL_X: begin state_d = ST_MLOAD; step_d = SP_GOAL_Y; end
          SP_LEN_Y, SP_GOAL_Y: state_d = ST_SLOAD;
          SP_DOT_Y, SP_CAR_X, SP_CAR_Y: state_d = ST_DLOAD;
          SP_KI:     state_d = ST_RATE;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (last_cnt_div) state_d = ST_DIV_END;
      end
      ST_DIV_END: begin
        case (step_q)
          SP_DOT_Y: begin state_d = ST_MLOAD; step_d = SP_CAR_X; end
          SP_CAR_X: begin state_d = ST_MLOAD; step_d = SP_CAR_Y; end
          default:  state_d = ST_CINIT;
        endcase
      end
      ST_SLOAD: state_d = ST_SQRT;
      ST_SQRT: begin
        if (last_cnt_sqrt) state_d = ST_SQRT_END;
      end
      ST_SQRT_END: begin
        if (step_q == SP_LEN_Y) begin
          state_d = ST_MLOAD;
          step_d  = SP_DOT_X;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CINIT:  state_d = car_zero ? ST_WRAP : ST_CORD_Y;
      ST_CORD_Y: state_d = ST_CORD_X;
      ST_CORD_X: state_d = last_cnt_cord ? ST_WRAP : ST_CORD_Y;
      ST_WRAP: begin
        state_d = ST_MLOAD;
        step_d  = SP_KP;
      end
      ST_RATE: begin
        state_d = ST_MLOAD;
        step_d  = SP_GOAL_X;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle_o = 1'b0;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: idle_o = 1'b1;
      ST_DONE: done_o = out_free_i;
      default: ;
    endcase
    res_o.angular_rate  = rate_q;
    res_o.goal_distance = gdist_q;
  end

  // datapath
  logic [MAGA_W:0]          msum;
  logic signed [ACC_W-1:0]  pext;
  logic [ACC_W-1:0]         half_ext;
  logic [LEN_W:0]           dt, ddiff;
  logic                     dge;
  logic [SREM_W-1:0]        st, strial;
  logic                     sge;
  logic [LEN_W-1:0]         sround;
  logic [QUO_W-1:0]         quo;
  logic signed [CAR_W-1:0]  cbase_x, cbase_y, qext;
  logic signed [CAR_W-1:0]  xa, ya;
  logic signed [CX_W-1:0]   xsh, ysh;
  logic signed [ANG_W-1:0]  atan_ext;
  logic [ANG_W-1:0]         pbias, psum;
  logic signed [16:0]       psi;
  logic signed [18:0]       err0, err1, err2;
  logic signed [SUM_W:0]    ssum;
  logic [ACC_W-1:0]         rbias, rsum;

  always_comb begin
    px_d = px_q;  py_d = py_q;  yaw_d = yaw_q;
    mcand_d = mcand_q;  prod_d = prod_q;  mneg_d = mneg_q;
    acc_d = acc_q;  wk_d = wk_q;  rem_d = rem_q;  root_d = root_q;  dneg_d = dneg_q;
    len_d = len_q;  reach_d = reach_q;  carx_d = carx_q;  cary_d = cary_q;
    cx_d = cx_q;  cy_d = cy_q;  ysav_d = ysav_q;  dir_d = dir_q;  ang_d = ang_q;
    err_d = err_q;  esum_d = esum_q;  prev_d = prev_q;
    rate_d = rate_q;  gdist_d = gdist_q;
    cnt_d = cnt_q;

    msum     = {1'b0, prod_q[PROD_W-1:MAGB_W]} + {1'b0, mcand_q};
    pext     = $signed({1'b0, prod_q[ACC_W-2:0]});
    half_ext = ACC_W'(len_q >> 1);
    dt       = {rem_q[LEN_W-1:0], wk_q[ACC_W-1]};
    dge      = dt >= {1'b0, len_q};
    ddiff    = dt - {1'b0, len_q};
    st       = {rem_q[SREM_W-3:0], wk_q[ACC_W-1:ACC_W-2]};
    strial   = {1'b0, root_q, 2'b01};
    sge      = st >= strial;
    sround   = root_q + LEN_W'(rem_q > SREM_W'(root_q));
    quo      = wk_q[QUO_W-1:0];
    qext     = $signed({2'b0, quo});
    cbase_x  = CAR_W'($signed({cfg_i.start_x[POS_W-1], cfg_i.start_x})
                     - $signed({px_q[POS_W-1], px_q}));
    cbase_y  = CAR_W'($signed({cfg_i.start_y[POS_W-1], cfg_i.start_y})
                     - $signed({py_q[POS_W-1], py_q}));
    xa       = carx_q[CAR_W-1] ? -carx_q : carx_q;
    ya       = carx_q[CAR_W-1] ? -cary_q : cary_q;
    xsh      = cx_q >>> cnt_q;
    ysh      = ysav_q >>> cnt_q;
    atan_ext = $signed({4'b0, atan_q24(cnt_q[4:0])});
    pbias    = ang_q[ANG_W-1] ? ANG_W'(1023) : ANG_W'(1024);
    psum     = ang_q + pbias;
    psi      = $signed(psum[ANG_W-1:11]);
    err0     = $signed({{2{psi[16]}}, psi}) - $signed({{3{yaw_q[YAW_W-1]}}, yaw_q});
    err1     = (err0 > 19'sd25736) ? err0 - 19'(TWO_PI_Q13) : err0;
    err2     = (err1 < -19'sd25736) ? err1 + 19'(TWO_PI_Q13) : err1;
    ssum     = $signed({esum_q[SUM_W-1], esum_q})
             + $signed({{17{err2[15]}}, err2[15:0]});
    rbias    = acc_q[ACC_W-1] ? ACC_W'(127) : ACC_W'(128);
    rsum     = acc_q + rbias;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          px_d  = pos_x_i;
          py_d  = pos_y_i;
          yaw_d = yaw_i;
        end
      end
      ST_MLOAD: begin
        mcand_d = mag_a;
        prod_d  = {{MAGA_W{1'b0}}, mag_b};
        mneg_d  = op_a[OPA_W-1] ^ op_b[OPB_W-1];
        cnt_d   = '0;
        if (step_q == SP_LEN_X || step_q == SP_DOT_X || step_q == SP_CAR_X ||
            step_q == SP_CAR_Y || step_q == SP_KP || step_q == SP_GOAL_X) begin
          acc_d = '0;
        end
      end
      ST_MUL: begin
        prod_d = prod_q[0] ? {msum, prod_q[MAGB_W-1:1]} : {1'b0, prod_q[PROD_W-1:1]};
        cnt_d  = cnt_q + 1'b1;
      end
      ST_MACC: acc_d = mneg_q ? acc_q - pext : acc_q + pext;
      ST_DLOAD: begin
        // |n| + d/2 in one subtract or add
        wk_d   = acc_q[ACC_W-1] ? half_ext - acc_q : acc_q + half_ext;
        dneg_d = acc_q[ACC_W-1];
        rem_d  = '0;
        cnt_d  = '0;
      end
      ST_DIV: begin
        rem_d = SREM_W'(dge ? ddiff[LEN_W-1:0] : dt[LEN_W-1:0]);
        wk_d  = {wk_q[ACC_W-2:0], dge};
        cnt_d = cnt_q + 1'b1;
      end
      ST_DIV_END: begin
        case (step_q)
          SP_DOT_Y: reach_d = quo[REACH_W-1:0] + REACH_W'(cfg_i.lookahead);
          SP_CAR_X: carx_d  = dneg_q ? cbase_x - qext : cbase_x + qext;
          default:  cary_d  = dneg_q ? cbase_y - qext : cbase_y + qext;
        endcase
      end
      ST_SLOAD: begin
        wk_d   = {acc_q[RAD_W-1:0], {(ACC_W-RAD_W){1'b0}}};
        rem_d  = '0;
        root_d = '0;
        cnt_d  = '0;
      end
      ST_SQRT: begin
        rem_d  = sge ? st - strial : st;
        root_d = {root_q[LEN_W-2:0], sge};
        wk_d   = {wk_q[ACC_W-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
      end
      ST_SQRT_END: begin
        if (step_q == SP_LEN_Y) len_d = sround;
        else gdist_d = sround[DIST_W-1:0];
      end
      ST_CINIT: begin
        // left half plane: fold by pi first
        if (carx_q[CAR_W-1]) begin
          ang_d = cary_q[CAR_W-1] ? -ANG_W'(PI_Q24) : ANG_W'(PI_Q24);
        end else begin
          ang_d = '0;
        end
        cx_d  = {{2{xa[CAR_W-1]}}, xa, 16'b0};
        cy_d  = {{2{ya[CAR_W-1]}}, ya, 16'b0};
        cnt_d = '0;
        if (car_zero) ang_d = '0;
      end
      ST_CORD_Y: begin
        dir_d  = (cy_q > 0);
        ysav_d = cy_q;
        cy_d   = (cy_q > 0) ? cy_q - xsh : cy_q + xsh;
      end
      ST_CORD_X: begin
        cx_d  = dir_q ? cx_q + ysh : cx_q - ysh;
        ang_d = dir_q ? ang_q + atan_ext : ang_q - atan_ext;
        cnt_d = cnt_q + 1'b1;
      end
      ST_WRAP: begin
        err_d = err2[ERR_W-1:0];
        if (ssum[SUM_W] != ssum[SUM_W-1]) begin
          esum_d = ssum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          esum_d = ssum[SUM_W-1:0];
        end
      end
      ST_RATE: begin
        prev_d = err_q;
        if (!rsum[ACC_W-1] && (|rsum[ACC_W-2:39])) begin
          rate_d = {1'b0, {(RATE_W-1){1'b1}}};
        end else if (rsum[ACC_W-1] && !(&rsum[ACC_W-2:39])) begin
          rate_d = {1'b1, {(RATE_W-1){1'b0}}};
        end else begin
          rate_d = rsum[39:8];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SP_LEN_X;
      cnt_q   <= '0;
      prev_q  <= '0;
      esum_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      esum_q  <= esum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;  py_q <= py_d;  yaw_q <= yaw_d;
    mcand_q <= mcand_d;  prod_q <= prod_d;  mneg_q <= mneg_d;
    acc_q <= acc_d;  wk_q <= wk_d;  rem_q <= rem_d;  root_q <= root_d;  dneg_q <= dneg_d;
    len_q <= len_d;  reach_q <= reach_d;  carx_q <= carx_d;  cary_q <= cary_d;
    cx_q <= cx_d;  cy_q <= cy_d;  ysav_q <= ysav_d;  dir_q <= dir_d;  ang_q <= ang_d;
    err_q <= err_d;  rate_q <= rate_d;  gdist_q <= gdist_d;
  end

endmodule
`default_nettype wire
